// ===== hdl/vint_delta_position_decoder_unit_assert.svh =====
// Assertion macros shared by the position decoder RTL.
`ifndef VINT_DELTA_POSITION_DECODER_UNIT_ASSERT_SVH
`define VINT_DELTA_POSITION_DECODER_UNIT_ASSERT_SVH

// Checked at every edge once reset is released.
`define VDPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define VDPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/vdpd_pkg.sv =====
// ----------------------------------------------------------------------------
// vdpd_pkg
// Types and codes shared by the VInt delta position decoder.
// ----------------------------------------------------------------------------
package vdpd_pkg;

    // Input beat kinds
    typedef enum logic [1:0] {
        KIND_DOC  = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    // Result error codes
    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_SHIFT = 3'd1,
        ERR_COUNT = 3'd2,
        ERR_TRUNC = 3'd3,
        ERR_EARLY = 3'd4
    } err_code_t;

    // Byte groups per VInt: the fifth continuation byte is an overflow
    localparam int unsigned GROUP_W   = 3;
    localparam logic [GROUP_W-1:0] LAST_GROUP = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] doc_freq;
        logic [7:0]         data_byte;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic               doc_last;
        err_code_t          error_code;
    } out_beat_t;

    // Result of one decode step
    typedef struct packed {
        logic      valid;
        out_beat_t beat;
    } step_result_t;

endpackage

// ===== hdl/vdpd_core.sv =====
// ----------------------------------------------------------------------------
// vdpd_core
// Decoder state and the combinational update for one input beat.
// ----------------------------------------------------------------------------
module vdpd_core
    import vdpd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  in_beat_t     beat,
    output step_result_t result
);

`include "vint_delta_position_decoder_unit_assert.svh"

    logic [31:0]        partial_reg, partial_next;
    logic [GROUP_W-1:0] group_reg, group_next;
    logic [31:0]        running_reg, running_next;
    logic [30:0]        owed_reg, owed_next;
    logic               failed_reg, failed_next;

    logic [31:0] shifted;
    logic [31:0] merged;
    logic [31:0] sum;

    // Place the seven value bits at the current group; the last group keeps only the low four
    always_comb begin
        case (group_reg)
            3'd0:    shifted = {25'd0, beat.data_byte[6:0]};
            3'd1:    shifted = {18'd0, beat.data_byte[6:0], 7'd0};
            3'd2:    shifted = {11'd0, beat.data_byte[6:0], 14'd0};
            3'd3:    shifted = {4'd0, beat.data_byte[6:0], 21'd0};
            3'd4:    shifted = {beat.data_byte[3:0], 28'd0};
            default: shifted = 32'd0;
        endcase
    end

    assign merged = partial_reg | shifted;
    assign sum    = running_reg + merged;

    // Next state and result
    always_comb begin
        partial_next = partial_reg;
        group_next   = group_reg;
        running_next = running_reg;
        owed_next    = owed_reg;
        failed_next  = failed_reg;
        result       = '0;

        if (step) begin
            case (beat.kind)
                KIND_END: begin
                    partial_next = '0;
                    group_next   = '0;
                    running_next = '0;
                    owed_next    = '0;
                    failed_next  = 1'b0;
                    if (!failed_reg && owed_reg != '0) begin
                        result.valid           = 1'b1;
                        result.beat.error_code = ERR_TRUNC;
                    end
                end
                KIND_DOC: begin
                    if (!failed_reg) begin
                        if (owed_reg != '0 || beat.doc_freq <= 0) begin
                            failed_next            = 1'b1;
                            owed_next              = '0;
                            partial_next           = '0;
                            group_next             = '0;
                            result.valid           = 1'b1;
                            result.beat.error_code = (owed_reg != '0) ? ERR_EARLY
                                                                       : ERR_COUNT;
                        end else begin
                            owed_next    = beat.doc_freq[30:0];
                            running_next = '0;
                            partial_next = '0;
                            group_next   = '0;
                        end
                    end
                end
                KIND_BYTE: begin
                    if (!failed_reg && owed_reg != '0) begin
                        if (!beat.data_byte[7]) begin
                            // Value complete: accumulate and emit
                            running_next           = sum;
                            partial_next           = '0;
                            group_next             = '0;
                            owed_next              = owed_reg - 31'd1;
                            result.valid           = 1'b1;
                            result.beat.position   = sum;
                            result.beat.doc_last   = (owed_reg == 31'd1);
                            result.beat.error_code = ERR_NONE;
                        end else if (group_reg == LAST_GROUP) begin
                            // Fifth continuation byte
                            failed_next            = 1'b1;
                            owed_next              = '0;
                            partial_next           = '0;
                            group_next             = '0;
                            result.valid           = 1'b1;
                            result.beat.error_code = ERR_SHIFT;
                        end else begin
                            partial_next = merged;
                            group_next   = group_reg + 3'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            group_reg   <= '0;
            running_reg <= '0;
            owed_reg    <= '0;
            failed_reg  <= 1'b0;
        end else begin
            partial_reg <= partial_next;
            group_reg   <= group_next;
            running_reg <= running_next;
            owed_reg    <= owed_next;
            failed_reg  <= failed_next;
        end
    end

    // A failed block owes nothing and holds no partial value
    `VDPD_ASSERT(a_failed_clear, failed_reg |-> (owed_reg == '0 && group_reg == '0), "failed state not cleared")
    // A value in progress only exists while positions are owed
    `VDPD_ASSERT(a_group_owed, (group_reg != '0) |-> (owed_reg != '0), "partial value with nothing owed")
    // Group index never passes the overflow group
    `VDPD_ASSERT(a_group_range, group_reg <= LAST_GROUP, "group index out of range")

endmodule

// ===== hdl/vint_delta_position_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// vint_delta_position_decoder_unit
// VInt delta position decoder with registered input and result stages.
// ----------------------------------------------------------------------------
// Accepts one beat per clock and presents its result, if any, on the m_
// channel from the result register, which it reaches through the input register.
// The input register feeds a combinational decode step (shift, OR and 32-bit
// add in vdpd_core) that loads the result register; throughput is one beat
// per cycle, set by that one-step state update, and falls only while the
// result register is held by m_ready low.
module vint_delta_position_decoder_unit
    import vdpd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

`include "vint_delta_position_decoder_unit_assert.svh"

    logic         in_valid_reg, in_valid_next;
    in_beat_t     in_data_reg;
    logic         out_valid_reg, out_valid_next;
    out_beat_t    out_data_reg;
    logic         step;
    step_result_t result;

    // Decode advances when the result slot is free or being drained
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    vdpd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .beat    (in_data_reg),
        .result  (result)
    );

    // Stage valid flags
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = result.valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (step && result.valid) begin
            out_data_reg <= result.beat;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Accepted beat always lands in the input register
    `VDPD_ASSERT(a_accept_load, (s_valid && s_ready) |=> in_valid_reg, "accepted beat lost")
    // Error results carry no position and no last flag
    `VDPD_ASSERT(a_err_payload, (m_valid && m_data.error_code != ERR_NONE) |-> (m_data.position == 0 && !m_data.doc_last), "error result with payload")
    // A result never overwrites one that was not taken
    `VDPD_ASSERT(a_no_overwrite, (out_valid_reg && !m_ready) |-> !step, "result overwritten")
    // Reset leaves both stages empty
    `VDPD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> (!in_valid_reg && !out_valid_reg), "stages not empty after reset")

endmodule

// ===== dv/vdpd_position_checker.sv =====
// ----------------------------------------------------------------------------
// vdpd_position_checker
// Watches both channels of the VInt delta position decoder, predicts each
// result beat from the accepted input beats and compares it field by field.
// ----------------------------------------------------------------------------
module vdpd_position_checker
    import vdpd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_beat_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_beat_t m_data,
    output int        fail_count,
    output int        positions_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the decoder state
    logic [31:0] partial_val;
    logic [5:0]  shift_amt;
    logic [31:0] run_pos;
    logic [30:0] owed;
    logic        failed;

    // Positions and error codes still to come out, oldest first
    out_beat_t   expected_positions[$];

    logic        emits;
    out_beat_t   predicted;
    out_beat_t   oldest;

    task automatic report_mismatch(input string msg);
        $display("%0t ns MISMATCH %s", $realtime, msg);
        fail_count++;
    endtask

    // One decode step: updates the shadow state, returns the result if any
    task automatic decode_beat(input in_beat_t beat, output logic has_res,
                               output out_beat_t res);
        err_code_t err;
        has_res = 1'b0;
        err     = ERR_NONE;
        res     = '{position: '0, doc_last: 1'b0, error_code: ERR_NONE};
        case (beat.kind)
            KIND_END: begin
                // truncated only if a clean document still owes positions
                if (!failed && owed != '0) begin
                    has_res        = 1'b1;
                    res.error_code = ERR_TRUNC;
                end
                partial_val = '0;
                shift_amt   = '0;
                run_pos     = '0;
                owed        = '0;
                failed      = 1'b0;
            end
            KIND_DOC: if (!failed) begin
                // early start wins over the count check
                if (owed != '0) begin
                    err = ERR_EARLY;
                end else if (beat.doc_freq <= 0) begin
                    err = ERR_COUNT;
                end else begin
                    owed        = beat.doc_freq[30:0];
                    run_pos     = '0;
                    partial_val = '0;
                    shift_amt   = '0;
                end
            end
            KIND_BYTE: if (!failed && owed != '0) begin
                // groups past bit 31 fall off the 32-bit value
                if (shift_amt < 6'd32)
                    partial_val = partial_val | (32'(beat.data_byte[6:0]) << shift_amt);
                if (!beat.data_byte[7]) begin
                    run_pos      = run_pos + partial_val;
                    partial_val  = '0;
                    shift_amt    = '0;
                    owed         = owed - 31'd1;
                    has_res      = 1'b1;
                    res.position = run_pos;
                    res.doc_last = (owed == '0);
                end else begin
                    shift_amt = shift_amt + 6'd7;
                    if (shift_amt >= 6'd32)
                        err = ERR_SHIFT;
                end
            end
            default: ;
        endcase
        // any fault: report once, then stick until end of block
        if (err != ERR_NONE) begin
            failed         = 1'b1;
            owed           = '0;
            partial_val    = '0;
            shift_amt      = '0;
            has_res        = 1'b1;
            res.error_code = err;
        end
    endtask

    // Compare finished results, then predict from the accepted input
    always @(posedge aclk) begin
        if (!aresetn) begin
            partial_val = '0;
            shift_amt   = '0;
            run_pos     = '0;
            owed        = '0;
            failed      = 1'b0;
            expected_positions.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_positions.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected beat: position %0d doc_last %0d code %0d",
                        m_data.position, m_data.doc_last, m_data.error_code));
                end else begin
                    oldest = expected_positions.pop_front();
                    if (m_data.position !== oldest.position)
                        report_mismatch($sformatf("position got %0d expected %0d",
                            m_data.position, oldest.position));
                    if (m_data.doc_last !== oldest.doc_last)
                        report_mismatch($sformatf("doc_last got %0d expected %0d",
                            m_data.doc_last, oldest.doc_last));
                    if (m_data.error_code !== oldest.error_code)
                        report_mismatch($sformatf("error_code got %0d expected %0d",
                            m_data.error_code, oldest.error_code));
                end
            end
            if (s_valid && s_ready) begin
                decode_beat(s_data, emits, predicted);
                if (emits)
                    expected_positions.insert(expected_positions.size(), predicted);
            end
        end
        positions_pending <= expected_positions.size();
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the VInt delta position decoder: a directed pass
// over the fault cases, then random blocks of documents whose VInts are
// mostly well formed, under three idling patterns and one long output stall.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vdpd_pkg::*;

    localparam int          RANDOM_ITEMS     = 500;
    localparam int          RECV_HOLD_CYCLES = 60;
    localparam int          DRAIN_CYCLES     = 10;
    localparam int          TIMEOUT_NS       = 5_000_000;
    localparam logic [1:0]  KIND_UNUSED      = 2'd3;

    // Ways a random block may be broken
    typedef enum int {
        FAULT_NONE,
        FAULT_TRUNC,
        FAULT_SHIFT,
        FAULT_EARLY,
        FAULT_COUNT,
        FAULT_IDLE_BYTES,
        FAULT_KIND_UNUSED
    } fault_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;
    int        fail_count;
    int        positions_pending;

    int        send_idle_pct = 7;
    int        recv_idle_pct = 59;
    int        items_sent    = 0;
    logic      long_hold_req  = 1'b0;
    logic      long_hold_done = 1'b0;

    vint_delta_position_decoder_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    vdpd_position_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data            (s_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data            (m_data),
        .fail_count        (fail_count),
        .positions_pending (positions_pending)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard limit on the run
    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off when asked
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (RECV_HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Offer one beat, with random idle cycles ahead of it
    task automatic send_beat(input in_beat_t beat, input bit counts);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        if (counts)
            items_sent++;
    endtask

    task automatic send_doc(input logic signed [31:0] freq, input bit counts);
        in_beat_t beat;
        beat.kind      = KIND_DOC;
        beat.doc_freq  = freq;
        beat.data_byte = 8'($urandom);
        send_beat(beat, counts);
    endtask

    task automatic send_byte(input logic [7:0] data, input bit counts);
        in_beat_t beat;
        beat.kind      = KIND_BYTE;
        beat.doc_freq  = $urandom;
        beat.data_byte = data;
        send_beat(beat, counts);
    endtask

    task automatic send_other(input logic [1:0] kind, input bit counts);
        in_beat_t beat;
        beat.kind      = kind;
        beat.doc_freq  = $urandom;
        beat.data_byte = 8'($urandom);
        send_beat(beat, counts);
    endtask

    // One VInt of the given number of 7-bit groups, random content
    task automatic send_vint(input int groups);
        for (int g = 0; g < groups; g++)
            send_byte({g != groups - 1, 7'($urandom)}, 1'b1);
    endtask

    // Mostly short VInts, now and then the full five groups
    function automatic int pick_groups();
        int roll;
        roll = $urandom_range(9, 0);
        if (roll < 5) return 1;
        if (roll < 7) return 2;
        if (roll < 8) return 3;
        if (roll < 9) return 4;
        return 5;
    endfunction

    // A block of documents, ended by end of block; a quarter carry a fault
    task automatic send_random_block();
        int     docs;
        int     npos;
        int     cut;
        fault_t fault;
        docs  = $urandom_range(4, 1);
        fault = ($urandom_range(3, 0) != 0) ? FAULT_NONE
                                             : fault_t'($urandom_range(6, 1));
        for (int d = 0; d < docs; d++) begin
            npos = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 7)
                                                : $urandom_range(6, 1);
            cut  = $urandom_range(npos - 1, 0);
            if (fault == FAULT_COUNT && d == docs - 1)
                send_doc($urandom_range(1, 0) ? 32'sd0 : {1'b1, 31'($urandom)}, 1'b1);
            else
                send_doc(npos, 1'b1);
            for (int p = 0; p < npos; p++) begin
                if (d == docs - 1 && p == cut) begin
                    if (fault == FAULT_TRUNC)
                        break;
                    case (fault)
                        FAULT_SHIFT: begin
                            repeat (5) send_byte({1'b1, 7'($urandom)}, 1'b1);
                        end
                        FAULT_EARLY: begin
                            send_doc({1'b0, 31'($urandom_range(32'h7FFF_FFFF, 1))}, 1'b1);
                        end
                        FAULT_KIND_UNUSED: begin
                            send_other(KIND_UNUSED, 1'b0);
                        end
                        default: ;
                    endcase
                end
                send_vint(pick_groups());
            end
        end
        // stray bytes with nothing owed
        if (fault == FAULT_IDLE_BYTES)
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
        send_other(KIND_END, 1'b1);
    endtask

    // Reset, directed cases, random blocks, drain, verdict
    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // idle stream: end, stray byte, unused kind
        send_other(KIND_END, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_other(KIND_UNUSED, 1'b0);
        // zero count, then beats ignored while failed
        send_doc(32'sd0, 1'b0);
        send_doc(32'sd5, 1'b0);
        send_other(KIND_END, 1'b0);
        // most negative count
        send_doc(32'sh8000_0000, 1'b0);
        send_other(KIND_END, 1'b0);
        // five-byte VInt with all value bits set, then early start
        send_doc(32'sd2, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_doc(32'sd1, 1'b0);
        send_other(KIND_END, 1'b0);
        // largest count, zero delta, truncated block
        send_doc(32'sh7FFF_FFFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_other(KIND_END, 1'b0);
        // fifth continuation byte
        send_doc(32'sd1, 1'b0);
        repeat (5) send_byte(8'h80, 1'b0);
        send_other(KIND_END, 1'b0);

        // random blocks; swap idling after a third, none for the last third
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                long_hold_req = 1'b1;
            end else if (items_sent >= RANDOM_ITEMS / 3) begin
                send_idle_pct = 59;
                recv_idle_pct = 7;
            end
            send_random_block();
        end
        s_valid <= 1'b0;

        // wait for the last results to come out
        @(posedge aclk);
        while (positions_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && positions_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
